// ----- sv/rcps_pkg.sv -----
// Shared types and constants for the ring cell pedestal subtraction block.
`timescale 1ns / 1ps
package rcps_pkg;

  localparam int CHANNELS   = 16;
  localparam int STOP_CELLS = 8;
  localparam int WORD_W     = 16;
  localparam int OFFSET_W   = 21;
  localparam int CORR_W     = 22;
  localparam int COUNTER_W  = 64;
  localparam int DEPTH_W    = 7;

  localparam logic [DEPTH_W-1:0] READ_DEPTH_RESET = 7'd68;

  typedef enum logic [2:0] {
    KIND_PPS     = 3'd0,
    KIND_TEN_MHZ = 3'd1,
    KIND_EVENT   = 3'd2,
    KIND_TRIGGER = 3'd3,
    KIND_CLOCK   = 3'd4,
    KIND_SAMPLE  = 3'd5
  } kind_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DATA = 1'b1
  } op_e;

  typedef struct packed {
    logic              en;
    logic [2:0]        col;
    logic [WORD_W-1:0] word;
  } stop_wr_t;

endpackage

// ----- sv/ring_cell_pedestal_subtract_core.sv -----
// Top level of the ring cell pedestal subtraction block.
`timescale 1ns / 1ps
// The block takes one word per clock cycle, load or event, while its output is not stalled.
// Each result passes through the stage 1 registers, where a sample's offset memory read is
// registered, and then the output register. The rate is set by the single offset memory, which
// serves either one load write or one sample read per cycle. The offset memory has no clearing
// pass, so the block is ready straight after reset; an offset must be loaded before any sample
// reads it. Stop cells are reduced modulo RING_CELLS through an input register stage and the
// stop cell store, and are ready well before the first sample of the event needs them.
module ring_cell_pedestal_subtract_core
  import rcps_pkg::*;
#(
  parameter int MAX_DEPTH  = 68,
  parameter int RING_CELLS = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [DEPTH_W-1:0]          cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [3:0]                  load_channel_i,
  input  logic [11:0]                 load_cell_i,
  input  logic signed [OFFSET_W-1:0]  load_offset_i,
  input  logic [WORD_W-1:0]           data_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  kind_o,
  output logic [3:0]                  channel_o,
  output logic [6:0]                  sample_index_o,
  output logic [11:0]                 ring_cell_o,
  output logic signed [CORR_W-1:0]    corrected_o,
  output logic [COUNTER_W-1:0]        counter_value_o
);

  localparam int EffMax = (MAX_DEPTH < 127) ? MAX_DEPTH : 127;
  localparam int TotMax = 8 * (2 * EffMax + 4);
  localparam int PosW   = $clog2(TotMax);
  localparam int TotW   = PosW + 1;
  localparam int RowW   = PosW - 3;
  localparam int CellW  = $clog2(RING_CELLS);
  localparam int AddrW  = $clog2(CHANNELS * RING_CELLS);
  localparam int HdrEnd = 12;

  logic [DEPTH_W-1:0]               read_depth_q;
  logic [PosW-1:0]                  pos_q, pos_d;
  logic [COUNTER_W-1:0]             acc_q, acc_d;

  logic                             v1_q, v1_d;
  kind_e                            kind1_q, kind1_d;
  logic [3:0]                       ch1_q, ch1_d;
  logic [6:0]                       j1_q, j1_d;
  logic [CellW-1:0]                 cell1_q, cell1_d;
  logic [WORD_W-1:0]                word1_q, word1_d;
  logic [COUNTER_W-1:0]             cnt1_q, cnt1_d;

  logic                             v2_q;
  kind_e                            kind2_q;
  logic [3:0]                       ch2_q;
  logic [6:0]                       j2_q;
  logic [11:0]                      cell2_q;
  logic [CORR_W-1:0]                corr2_q;
  logic [COUNTER_W-1:0]             cnt2_q;

  logic [DEPTH_W-1:0]               eff_depth;
  logic [TotW-1:0]                  total;
  logic [PosW-1:0]                  pos_cur;
  logic [RowW-1:0]                  row, r4, j_full;
  logic [2:0]                       col;
  logic                             is_low;
  logic [6:0]                       j;
  logic [3:0]                       ch;
  logic [CellW:0]                   cell_sum;
  logic [CellW-1:0]                 ring_idx;
  logic                             accept, is_data, in_hdr, in_stop, in_sample;
  logic                             hdr_emit;
  kind_e                            hdr_kind;
  logic                             s2_free, s1_free;
  logic                             ram_we, ram_re;
  logic [AddrW-1:0]                 ram_waddr, ram_raddr;
  logic [OFFSET_W-1:0]              ram_rdata;
  logic [CORR_W-1:0]                corr;
  stop_wr_t                         stop_wr;
  logic [STOP_CELLS-1:0][CellW-1:0] stop_cells;

  assign cfg_ready_o = 1'b1;

  assign eff_depth = (read_depth_q == '0) ? DEPTH_W'(1) :
                     ((int'(read_depth_q) > MAX_DEPTH) ? DEPTH_W'(MAX_DEPTH) : read_depth_q);
  assign total     = TotW'({eff_depth, 4'b0000}) + TotW'(32);
  assign pos_cur   = (TotW'(pos_q) >= total) ? '0 : pos_q;
  assign pos_d     = (TotW'(pos_cur) + TotW'(1) >= total) ? '0 : pos_cur + PosW'(1);

  assign row       = pos_cur[PosW-1:3];
  assign col       = pos_cur[2:0];
  assign r4        = row - RowW'(4);
  assign is_low    = r4 >= RowW'(eff_depth);
  assign j_full    = is_low ? r4 - RowW'(eff_depth) : r4;
  assign j         = 7'(j_full);
  assign ch        = {is_low, col};
  assign cell_sum  = (CellW+1)'(stop_cells[col]) + (CellW+1)'(j);
  assign ring_idx  = (cell_sum >= (CellW+1)'(RING_CELLS)) ?
                     CellW'(cell_sum - (CellW+1)'(RING_CELLS)) : CellW'(cell_sum);

  assign s2_free    = !v2_q || !out_stall_i;
  assign s1_free    = !v1_q || s2_free;
  assign in_stall_o = !s1_free;
  assign accept     = in_valid_i && s1_free;
  assign is_data    = opcode_i == OP_DATA;
  assign in_hdr     = pos_cur < PosW'(HdrEnd);
  assign in_stop    = row == RowW'(3);
  assign in_sample  = row >= RowW'(4);

  always_comb begin
    acc_d    = acc_q;
    hdr_emit = 1'b0;
    hdr_kind = KIND_PPS;
    case (pos_cur) inside
      1, 2, 4, 6, 8:  acc_d = COUNTER_W'(data_word_i);
      3, 5, 7, 9, 10, 11: acc_d = {acc_q[COUNTER_W-WORD_W-1:0], data_word_i};
      default: acc_d = acc_q;
    endcase
    case (pos_cur) inside
      1: begin
        hdr_emit = 1'b1;
        hdr_kind = KIND_PPS;
      end
      3: begin
        hdr_emit = 1'b1;
        hdr_kind = KIND_TEN_MHZ;
      end
      5: begin
        hdr_emit = 1'b1;
        hdr_kind = KIND_EVENT;
      end
      7: begin
        hdr_emit = 1'b1;
        hdr_kind = KIND_TRIGGER;
      end
      11: begin
        hdr_emit = 1'b1;
        hdr_kind = KIND_CLOCK;
      end
      default: begin
        hdr_emit = 1'b0;
        hdr_kind = KIND_PPS;
      end
    endcase
  end

  assign stop_wr.en   = accept && is_data && in_stop;
  assign stop_wr.col  = col;
  assign stop_wr.word = data_word_i;

  rcps_stop_cells #(
    .RING_CELLS (RING_CELLS)
  ) u_stop_cells (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (stop_wr),
    .cells_o (stop_cells)
  );

  assign ram_we    = accept && !is_data && (int'(load_cell_i) < RING_CELLS);
  assign ram_waddr = AddrW'(load_channel_i) * AddrW'(RING_CELLS) +
                     AddrW'(load_cell_i[CellW-1:0]);
  assign ram_re    = accept && is_data && in_sample;
  assign ram_raddr = AddrW'(ch) * AddrW'(RING_CELLS) + AddrW'(ring_idx);

  rcps_ram #(
    .WIDTH (OFFSET_W),
    .DEPTH (CHANNELS * RING_CELLS)
  ) u_offset_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (load_offset_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    v1_d    = v1_q;
    kind1_d = kind1_q;
    ch1_d   = ch1_q;
    j1_d    = j1_q;
    cell1_d = cell1_q;
    word1_d = word1_q;
    cnt1_d  = cnt1_q;
    if (s1_free) begin
      v1_d = accept && is_data && ((in_hdr && hdr_emit) || in_sample);
      if (in_sample) begin
        kind1_d = KIND_SAMPLE;
        ch1_d   = ch;
        j1_d    = j;
        cell1_d = ring_idx;
        word1_d = data_word_i;
        cnt1_d  = '0;
      end else begin
        kind1_d = hdr_kind;
        ch1_d   = '0;
        j1_d    = '0;
        cell1_d = '0;
        word1_d = '0;
        cnt1_d  = acc_d;
      end
    end
  end

  assign corr = {2'b00, word1_q, 4'b0000} - {ram_rdata[OFFSET_W-1], ram_rdata};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_depth_q <= READ_DEPTH_RESET;
      pos_q        <= '0;
      acc_q        <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        read_depth_q <= cfg_data_i;
      end
      if (accept && is_data) begin
        pos_q <= pos_d;
        if (in_hdr) begin
          acc_q <= acc_d;
        end
      end
      v1_q <= v1_d;
      if (s2_free) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind1_q <= kind1_d;
    ch1_q   <= ch1_d;
    j1_q    <= j1_d;
    cell1_q <= cell1_d;
    word1_q <= word1_d;
    cnt1_q  <= cnt1_d;
    if (s2_free && v1_q) begin
      kind2_q <= kind1_q;
      ch2_q   <= ch1_q;
      j2_q    <= j1_q;
      cell2_q <= 12'(cell1_q);
      corr2_q <= (kind1_q == KIND_SAMPLE) ? corr : '0;
      cnt2_q  <= cnt1_q;
    end
  end

  assign out_valid_o     = v2_q;
  assign kind_o          = kind2_q;
  assign channel_o       = ch2_q;
  assign sample_index_o  = j2_q;
  assign ring_cell_o     = cell2_q;
  assign corrected_o     = corr2_q;
  assign counter_value_o = cnt2_q;

endmodule

// ----- sv/rcps_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module rcps_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/rcps_stop_cells.sv -----
// Stop cell store with a two-stage reduction of the raw word modulo the ring size.
`timescale 1ns / 1ps
module rcps_stop_cells
  import rcps_pkg::*;
#(
  parameter int RING_CELLS = 4096
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  stop_wr_t                                        wr_i,
  output logic [STOP_CELLS-1:0][$clog2(RING_CELLS)-1:0]   cells_o
);

  localparam int CellW  = $clog2(RING_CELLS);
  localparam int RecipW = 33 - CellW;
  localparam int ProdW  = WORD_W + RecipW;
  localparam int QW     = 17 - CellW;
  localparam longint unsigned Recip =
    ((64'd1 << 32) + 64'(RING_CELLS) - 64'd1) / 64'(RING_CELLS);

  logic                                 va_q;
  logic [2:0]                           cola_q;
  logic [WORD_W-1:0]                    worda_q;
  logic [QW-1:0]                        qa_q;
  logic [ProdW-1:0]                     prod;
  logic [16:0]                          qm;
  logic [16:0]                          rem;
  logic [STOP_CELLS-1:0][CellW-1:0]     cells_q;

  assign prod = ProdW'(wr_i.word) * ProdW'(Recip);
  assign qm   = 17'(qa_q) * 17'(RING_CELLS);
  assign rem  = 17'(worda_q) - qm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      cells_q <= '0;
    end else begin
      va_q <= wr_i.en;
      if (va_q) begin
        cells_q[cola_q] <= rem[CellW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      cola_q  <= wr_i.col;
      worda_q <= wr_i.word;
      qa_q    <= prod[32 +: QW];
    end
  end

  assign cells_o = cells_q;

endmodule

// ----- sv/rcps_checker.sv -----
// Port-level checker for the ring cell pedestal subtraction block, bound to the top level.
`timescale 1ns / 1ps
module rcps_checker
  import rcps_pkg::*;
(
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [2:0]                  kind_o,
  input logic [3:0]                  channel_o,
  input logic [6:0]                  sample_index_o,
  input logic [11:0]                 ring_cell_o,
  input logic signed [CORR_W-1:0]    corrected_o,
  input logic [COUNTER_W-1:0]        counter_value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(corrected_o) && $stable(counter_value_o) && $stable(channel_o))
    else $error("Stalled output word changed.");

  a_counter_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_SAMPLE |-> channel_o == '0 && sample_index_o == '0 &&
      ring_cell_o == '0 && corrected_o == '0)
    else $error("Counter word carries sample fields.");

  a_sample_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_SAMPLE |-> counter_value_o == '0)
    else $error("Sample word carries a counter value.");

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("Input stalled while the output is empty.");

endmodule

bind ring_cell_pedestal_subtract_core rcps_checker u_rcps_checker (.*);

// ----- dv/ring_cell_pedestal_subtract_core_tb.sv -----
// Self-checking testbench for the ring cell pedestal subtraction block.
`timescale 1ns / 1ps
module ring_cell_pedestal_subtract_core_tb;
  import rcps_pkg::*;

  localparam int DEPTH_MAX = 68;

  typedef struct packed {
    op_e                        op;
    logic [3:0]                 ch;
    logic [11:0]                ring_pos;
    logic signed [OFFSET_W-1:0] offset;
    logic [WORD_W-1:0]          word;
  } in_word_t;

  typedef struct packed {
    kind_e                    kind;
    logic [3:0]               channel;
    logic [6:0]               sample_index;
    logic [11:0]              ring_cell;
    logic signed [CORR_W-1:0] corrected;
    logic [COUNTER_W-1:0]     counter_value;
  } result_t;

  typedef struct packed {
    logic [DEPTH_W-1:0]    depth;
    logic [10:0]           pos;
    logic [7:0][11:0]      stop;
    logic [COUNTER_W-1:0]  acc;
  } decoder_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [DEPTH_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic opcode_i = 1'b0;
  logic [3:0] load_channel_i = '0;
  logic [11:0] load_cell_i = '0;
  logic signed [OFFSET_W-1:0] load_offset_i = '0;
  logic [WORD_W-1:0] data_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] kind_o;
  logic [3:0] channel_o;
  logic [6:0] sample_index_o;
  logic [11:0] ring_cell_o;
  logic signed [CORR_W-1:0] corrected_o;
  logic [COUNTER_W-1:0] counter_value_o;

  ring_cell_pedestal_subtract_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .load_channel_i  (load_channel_i),
    .load_cell_i     (load_cell_i),
    .load_offset_i   (load_offset_i),
    .data_word_i     (data_word_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .channel_o       (channel_o),
    .sample_index_o  (sample_index_o),
    .ring_cell_o     (ring_cell_o),
    .corrected_o     (corrected_o),
    .counter_value_o (counter_value_o)
  );

  in_word_t feed_q[$];
  result_t  result_q[$];
  decoder_t lookahead;
  decoder_t shadow;
  logic signed [OFFSET_W-1:0] pedestal_mem [65536];
  bit       written [65536];
  in_word_t cur;
  int       mismatches = 0;
  int       queued = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  int       in_quiet = 0;
  int       out_quiet = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Walks the event layout for one data word; returns 1 when the word yields a result.
  // For a sample the pedestal address is returned and the subtraction is left to the caller.
  function automatic bit decode_word(inout decoder_t s, input logic [WORD_W-1:0] w,
                                     output result_t r, output logic [15:0] addr);
    int unsigned d, total, p, row, col, j;
    logic [3:0] ch;
    r = '0;
    addr = '0;
    d = s.depth;
    if (d < 1) d = 1;
    if (d > DEPTH_MAX) d = DEPTH_MAX;
    total = 8 * (2 * d + 4);
    if (s.pos >= total) s.pos = '0;
    p = s.pos;
    s.pos = (p + 1 >= total) ? 11'd0 : 11'(p + 1);
    row = p >> 3;
    col = p & 7;
    if (row == 0 || (row == 1 && col < 4)) begin
      if (p == 1 || p == 2 || p == 4 || p == 6 || p == 8) s.acc = 64'(w);
      else if (p != 0) s.acc = {s.acc[47:0], w};
      r.counter_value = s.acc;
      case (p)
        1: r.kind = KIND_PPS;
        3: r.kind = KIND_TEN_MHZ;
        5: r.kind = KIND_EVENT;
        7: r.kind = KIND_TRIGGER;
        11: r.kind = KIND_CLOCK;
        default: return 1'b0;
      endcase
      return 1'b1;
    end
    if (row < 3) return 1'b0;
    if (row == 3) begin
      s.stop[col] = w[11:0];
      return 1'b0;
    end
    j = row - 4;
    ch = 4'(col);
    if (j >= d) begin
      j -= d;
      ch += 4'd8;
    end
    r.kind = KIND_SAMPLE;
    r.channel = ch;
    r.sample_index = 7'(j);
    r.ring_cell = 12'(s.stop[col] + j);
    addr = {ch, r.ring_cell};
    return 1'b1;
  endfunction

  function automatic int pick_idle(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 299) == 0) quiet = $urandom_range(20, 100);
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 16);
  endfunction

  function automatic logic signed [OFFSET_W-1:0] pick_offset();
    case ($urandom_range(0, 9))
      0: return 21'h100000;
      1: return 21'h0FFFFF;
      default: return 21'($urandom());
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'(($urandom_range(0, 15) << 12) | (4088 + $urandom_range(0, 7)));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic push_load(input logic [3:0] ch, input logic [11:0] ring_pos,
                           input logic signed [OFFSET_W-1:0] offset);
    in_word_t it;
    it.op = OP_LOAD;
    it.ch = ch;
    it.ring_pos = ring_pos;
    it.offset = offset;
    it.word = 16'($urandom());
    written[{ch, ring_pos}] = 1'b1;
    feed_q.push_back(it);
    queued++;
  endtask

  task automatic push_word(input logic [WORD_W-1:0] w);
    result_t r;
    logic [15:0] addr;
    in_word_t it;
    if ($urandom_range(0, 99) < 8) push_load(4'($urandom()), 12'($urandom()), pick_offset());
    if (decode_word(lookahead, w, r, addr) && r.kind == KIND_SAMPLE && !written[addr])
      push_load(addr[15:12], addr[11:0], pick_offset());
    it.op = OP_DATA;
    it.ch = 4'($urandom());
    it.ring_pos = 12'($urandom());
    it.offset = 21'($urandom());
    it.word = w;
    feed_q.push_back(it);
    queued++;
  endtask

  // Loads produce no result, so a short settling time follows the last result.
  task automatic drain();
    do @(negedge clk_i); while (feed_q.size() != 0 || in_valid_i || result_q.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_depth(input logic [DEPTH_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    lookahead.depth = value;
    shadow.depth = value;
  endtask

  task automatic run_phase(input logic [DEPTH_W-1:0] depth, input int words);
    drain();
    write_depth(depth);
    repeat (words) push_word(pick_word());
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    result_t r;
    logic [15:0] addr;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        if (cur.op == OP_LOAD) begin
          pedestal_mem[{cur.ch, cur.ring_pos}] = cur.offset;
        end else if (decode_word(shadow, cur.word, r, addr)) begin
          if (r.kind == KIND_SAMPLE)
            r.corrected = 22'(int'({2'b00, cur.word, 4'b0000}) - int'(pedestal_mem[addr]));
          result_q.push_back(r);
        end
      end
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (feed_q.size() != 0) begin
        cur = feed_q.pop_front();
        opcode_i <= cur.op;
        load_channel_i <= cur.ch;
        load_cell_i <= cur.ring_pos;
        load_offset_i <= cur.offset;
        data_word_i <= cur.word;
        in_valid_i <= 1'b1;
        gap_left = pick_idle(in_quiet);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          mismatches++;
          $display("%0t: result word with nothing expected, actual kind %0d", $time, kind_o);
        end else begin
          e = result_q.pop_front();
          check_field("kind", 64'(e.kind), 64'(kind_o));
          check_field("channel", 64'(e.channel), 64'(channel_o));
          check_field("sample_index", 64'(e.sample_index), 64'(sample_index_o));
          check_field("ring_cell", 64'(e.ring_cell), 64'(ring_cell_o));
          check_field("corrected", 64'(e.corrected), 64'(corrected_o));
          check_field("counter_value", e.counter_value, counter_value_o);
        end
      end
      if (stall_left == 0) stall_left = pick_idle(out_quiet);
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin : stimulus
    lookahead = '0;
    lookahead.depth = READ_DEPTH_RESET;
    shadow = lookahead;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_load(4'd0, 12'd0, 21'h100000);
    push_load(4'd15, 12'd4095, 21'h0FFFFF);
    push_load(4'd5, 12'd2048, 21'h000000);
    push_load(4'd10, 12'd1, 21'h1FFFFF);
    push_word(16'hFFFF); push_word(16'h8001); push_word(16'hFFFF); push_word(16'h0000);
    push_word(16'h0000); push_word(16'hFFFF); push_word(16'h1234); push_word(16'hABCD);
    push_word(16'hFFFF); push_word(16'h0000); push_word(16'hFFFF); push_word(16'h0001);
    push_word(16'hFFFF); push_word(16'hFFFF); push_word(16'hFFFF); push_word(16'hFFFF);

    run_phase(7'd1, 100);
    run_phase(7'd0, 60);
    run_phase(7'd127, 40);
    run_phase(7'd69, 40);
    run_phase(7'd6, 120);
    run_phase(7'd2, 100);
    run_phase(7'd68, 40);
    while (queued < 1200) run_phase(7'($urandom_range(1, 8)), $urandom_range(20, 100));
    drain();

    if (mismatches == 0) begin
      $display("ring_cell_pedestal_subtract_core_tb: PASS");
    end else begin
      $display("ring_cell_pedestal_subtract_core_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("ring_cell_pedestal_subtract_core_tb: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rcps_pkg.sv
sv/rcps_ram.sv
sv/rcps_stop_cells.sv
sv/ring_cell_pedestal_subtract_core.sv
sv/rcps_checker.sv
dv/ring_cell_pedestal_subtract_core_tb.sv
